// ===== sv/hrlp_pkg.sv =====
// hrlp_pkg: types, widths and constants shared by the hsv to rgb12 led packer
// stage structs for the six-stage pipeline and scaling reciprocals
// no dependencies
`default_nettype none

package hrlp_pkg;

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int LVL_W   = 12;
   localparam int FRAME_W = 48;
   localparam int PAD_W   = 4;

   // conversion constants
   localparam int CHAN_MAX     = 255;
   localparam int SECTOR_WIDTH = 43;
   localparam int OFF_MAX      = 42;
   localparam int SCALE_NUM    = 273;
   localparam int P_DEN        = 17 * CHAN_MAX;
   localparam int QT_DEN       = 17 * CHAN_MAX * OFF_MAX;
   localparam int FULL_SPAN    = CHAN_MAX * OFF_MAX;
   localparam int LEVEL_MAX    = 4095;

   // intermediate widths
   localparam int OFF_W     = 6;
   localparam int SPAN_W    = 14;
   localparam int P_RAW_W   = 16;
   localparam int QT_RAW_W  = 22;
   localparam int P_N_W     = 25;
   localparam int QT_N_W    = 30;
   localparam int QUO_W     = LVL_W + 1;

   // reciprocal multipliers: ceil(2^k / d) with k = operand bits + ceil(log2 d),
   // exact floor division for every operand below 2^operand bits
   localparam int P_SHIFT     = P_N_W + 13;
   localparam int QT_SHIFT    = QT_N_W + 18;
   localparam int P_MAGIC_W   = 26;
   localparam int QT_MAGIC_W  = 31;
   localparam int P_PROD_W    = P_N_W + P_MAGIC_W;
   localparam int QT_PROD_W   = QT_N_W + QT_MAGIC_W;

   localparam logic [P_MAGIC_W-1:0] P_MAGIC = P_MAGIC_W'(
      ((64'd1 << P_SHIFT) + 64'(P_DEN) - 64'd1) / 64'(P_DEN));
   localparam logic [QT_MAGIC_W-1:0] QT_MAGIC = QT_MAGIC_W'(
      ((64'd1 << QT_SHIFT) + 64'(QT_DEN) - 64'd1) / 64'(QT_DEN));

   // hue sectors, named after the colours they run between
   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } sector_type;

   typedef struct packed {
      logic [BYTE_W-1:0] led_index;
      logic [BYTE_W-1:0] hue;
      logic [BYTE_W-1:0] saturation;
      logic [BYTE_W-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  led_out;
      logic [LVL_W-1:0]   red_level;
      logic [LVL_W-1:0]   green_level;
      logic [LVL_W-1:0]   blue_level;
      logic [FRAME_W-1:0] packed_frame;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  led;
      sector_type         sec;
      logic [OFF_W-1:0]   off;
      logic [BYTE_W-1:0]  sat;
      logic [BYTE_W-1:0]  bright;
      logic [P_RAW_W-1:0] p_raw;
      logic               gray;
      logic               black;
   } s1_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  led;
      sector_type         sec;
      logic               gray;
      logic               black;
      logic [BYTE_W-1:0]  bright;
      logic [P_RAW_W-1:0] p_raw;
      logic [SPAN_W-1:0]  so;
      logic [SPAN_W-1:0]  sc;
   } s2_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   led;
      sector_type          sec;
      logic                gray;
      logic                black;
      logic [BYTE_W-1:0]   bright;
      logic [P_RAW_W-1:0]  p_raw;
      logic [QT_RAW_W-1:0] q_raw;
      logic [QT_RAW_W-1:0] t_raw;
   } s3_type;

   typedef struct packed {
      logic [BYTE_W-1:0] led;
      sector_type        sec;
      logic              gray;
      logic              black;
      logic [BYTE_W-1:0] bright;
      logic [P_N_W-1:0]  p_n;
      logic [QT_N_W-1:0] q_n;
      logic [QT_N_W-1:0] t_n;
   } s4_type;

   typedef struct packed {
      logic [BYTE_W-1:0] led;
      sector_type        sec;
      logic              gray;
      logic              black;
      logic [BYTE_W-1:0] bright;
      logic [QUO_W-1:0]  p_quo;
      logic [QUO_W-1:0]  q_quo;
      logic [QUO_W-1:0]  t_quo;
   } s5_type;

endpackage

`default_nettype wire

// ===== sv/hrlp_front.sv =====
// hrlp_front: first three pipeline stages, hue sector split and raw p, q, t
// products of brightness and saturation
// depends on hrlp_pkg
`default_nettype none

module hrlp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  hrlp_pkg::req_type in_data,
   output logic            in_ready,
   output logic            out_valid,
   output hrlp_pkg::s3_type out_data,
   input  logic            out_ready
);
   import hrlp_pkg::*;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   logic   v1_ff, v2_ff, v3_ff;
   logic   ready1, ready2, ready3;
   logic [BYTE_W-1:0] base;

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: sector and offset, p product
   always_comb begin
      s1_in = '0;
      base  = '0;
      if (in_data.hue >= BYTE_W'(SECTOR_WIDTH * 5)) begin
         s1_in.sec = SEC_MR;
         base      = BYTE_W'(SECTOR_WIDTH * 5);
      end else if (in_data.hue >= BYTE_W'(SECTOR_WIDTH * 4)) begin
         s1_in.sec = SEC_BM;
         base      = BYTE_W'(SECTOR_WIDTH * 4);
      end else if (in_data.hue >= BYTE_W'(SECTOR_WIDTH * 3)) begin
         s1_in.sec = SEC_CB;
         base      = BYTE_W'(SECTOR_WIDTH * 3);
      end else if (in_data.hue >= BYTE_W'(SECTOR_WIDTH * 2)) begin
         s1_in.sec = SEC_GC;
         base      = BYTE_W'(SECTOR_WIDTH * 2);
      end else if (in_data.hue >= BYTE_W'(SECTOR_WIDTH)) begin
         s1_in.sec = SEC_YG;
         base      = BYTE_W'(SECTOR_WIDTH);
      end else begin
         s1_in.sec = SEC_RY;
         base      = '0;
      end
      s1_in.off    = OFF_W'(in_data.hue - base);
      s1_in.led    = in_data.led_index;
      s1_in.sat    = in_data.saturation;
      s1_in.bright = in_data.brightness;
      s1_in.p_raw  = P_RAW_W'(in_data.brightness) *
                     P_RAW_W'(BYTE_W'(CHAN_MAX) - in_data.saturation);
      s1_in.gray   = (in_data.saturation == '0);
      s1_in.black  = (in_data.brightness == '0);
   end

   // stage 2: saturation times offset and its complement
   always_comb begin
      s2_in        = '0;
      s2_in.led    = s1_ff.led;
      s2_in.sec    = s1_ff.sec;
      s2_in.gray   = s1_ff.gray;
      s2_in.black  = s1_ff.black;
      s2_in.bright = s1_ff.bright;
      s2_in.p_raw  = s1_ff.p_raw;
      s2_in.so     = SPAN_W'(s1_ff.sat) * SPAN_W'(s1_ff.off);
      s2_in.sc     = SPAN_W'(s1_ff.sat) * SPAN_W'(OFF_W'(OFF_MAX) - s1_ff.off);
   end

   // stage 3: brightness times the falling and rising spans
   always_comb begin
      s3_in        = '0;
      s3_in.led    = s2_ff.led;
      s3_in.sec    = s2_ff.sec;
      s3_in.gray   = s2_ff.gray;
      s3_in.black  = s2_ff.black;
      s3_in.bright = s2_ff.bright;
      s3_in.p_raw  = s2_ff.p_raw;
      s3_in.q_raw  = QT_RAW_W'(s2_ff.bright) * QT_RAW_W'(SPAN_W'(FULL_SPAN) - s2_ff.so);
      s3_in.t_raw  = QT_RAW_W'(s2_ff.bright) * QT_RAW_W'(SPAN_W'(FULL_SPAN) - s2_ff.sc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) s1_ff <= s1_in;
      if (ready2) s2_ff <= s2_in;
      if (ready3) s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

`default_nettype wire

// ===== sv/hrlp_scale.sv =====
// hrlp_scale: stages four and five, scale p, q, t by 273 and divide by the
// fixed denominators through reciprocal multiplication
// depends on hrlp_pkg
`default_nettype none

module hrlp_scale (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  hrlp_pkg::s3_type in_data,
   output logic            in_ready,
   output logic            out_valid,
   output hrlp_pkg::s5_type out_data,
   input  logic            out_ready
);
   import hrlp_pkg::*;

   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   logic   v4_ff, v5_ff;
   logic   ready4, ready5;
   logic [P_PROD_W-1:0]  p_prod;
   logic [QT_PROD_W-1:0] q_prod;
   logic [QT_PROD_W-1:0] t_prod;

   assign ready5   = !v5_ff || out_ready;
   assign ready4   = !v4_ff || ready5;
   assign in_ready = ready4;

   always_comb begin
      s4_in        = '0;
      s4_in.led    = in_data.led;
      s4_in.sec    = in_data.sec;
      s4_in.gray   = in_data.gray;
      s4_in.black  = in_data.black;
      s4_in.bright = in_data.bright;
      s4_in.p_n    = P_N_W'(in_data.p_raw) * P_N_W'(SCALE_NUM);
      s4_in.q_n    = QT_N_W'(in_data.q_raw) * QT_N_W'(SCALE_NUM);
      s4_in.t_n    = QT_N_W'(in_data.t_raw) * QT_N_W'(SCALE_NUM);
   end

   // truncating division: the high bits of the reciprocal product
   always_comb begin
      p_prod       = P_PROD_W'(s4_ff.p_n) * P_PROD_W'(P_MAGIC);
      q_prod       = QT_PROD_W'(s4_ff.q_n) * QT_PROD_W'(QT_MAGIC);
      t_prod       = QT_PROD_W'(s4_ff.t_n) * QT_PROD_W'(QT_MAGIC);
      s5_in        = '0;
      s5_in.led    = s4_ff.led;
      s5_in.sec    = s4_ff.sec;
      s5_in.gray   = s4_ff.gray;
      s5_in.black  = s4_ff.black;
      s5_in.bright = s4_ff.bright;
      s5_in.p_quo  = p_prod[P_PROD_W-1:P_SHIFT];
      s5_in.q_quo  = q_prod[QT_PROD_W-1:QT_SHIFT];
      s5_in.t_quo  = t_prod[QT_PROD_W-1:QT_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (ready4) v4_ff <= in_valid;
         if (ready5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) s4_ff <= s4_in;
      if (ready5) s5_ff <= s5_in;
   end

   assign out_valid = v5_ff;
   assign out_data  = s5_ff;

endmodule

`default_nettype wire

// ===== sv/hrlp_out.sv =====
// hrlp_out: last stage, clamps the levels, routes them by sector, handles
// gray and black, packs the frame into the output register
// depends on hrlp_pkg
`default_nettype none

module hrlp_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hrlp_pkg::s5_type in_data,
   output logic             in_ready,
   output logic             rsp_valid,
   output hrlp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);
   import hrlp_pkg::*;

   rsp_type rsp_in, rsp_ff;
   logic    v6_ff;
   logic    ready6;
   logic [LVL_W-1:0] full, p_lvl, q_lvl, t_lvl;
   logic [LVL_W-1:0] red, green, blue;

   assign ready6   = !v6_ff || !rsp_stall;
   assign in_ready = ready6;

   always_comb begin
      full  = {in_data.bright, {PAD_W{1'b0}}};
      p_lvl = (in_data.p_quo > QUO_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX)
                                                  : in_data.p_quo[LVL_W-1:0];
      q_lvl = (in_data.q_quo > QUO_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX)
                                                  : in_data.q_quo[LVL_W-1:0];
      t_lvl = (in_data.t_quo > QUO_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX)
                                                  : in_data.t_quo[LVL_W-1:0];
      if (in_data.gray) begin
         red   = full;
         green = full;
         blue  = full;
      end else if (in_data.black) begin
         red   = '0;
         green = '0;
         blue  = '0;
      end else begin
         case (in_data.sec)
            SEC_RY: begin
               red = full;  green = t_lvl; blue = p_lvl;
            end
            SEC_YG: begin
               red = q_lvl; green = full;  blue = p_lvl;
            end
            SEC_GC: begin
               red = p_lvl; green = full;  blue = t_lvl;
            end
            SEC_CB: begin
               red = p_lvl; green = q_lvl; blue = full;
            end
            SEC_BM: begin
               red = t_lvl; green = p_lvl; blue = full;
            end
            default: begin
               red = full;  green = p_lvl; blue = q_lvl;
            end
         endcase
      end
      rsp_in.led_out      = in_data.led;
      rsp_in.red_level    = red;
      rsp_in.green_level  = green;
      rsp_in.blue_level   = blue;
      rsp_in.packed_frame = {in_data.led, red, green, blue, {PAD_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (ready6) begin
         v6_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready6) rsp_ff <= rsp_in;
   end

   assign rsp_valid = v6_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb12_led_packer_unit.sv =====
// hsv_to_rgb12_led_packer_unit: top level of the hsv to rgb12 led packer
// instantiates hrlp_front, hrlp_scale and hrlp_out; uses hrlp_pkg
//
// usage
//   req_ channel carries one led colour item: index, hue, saturation and
//   brightness. rsp_ channel returns the led index, 12-bit red, green and
//   blue levels and the 48-bit frame (led byte, three levels, zero nibble).
//   an item is taken at a rising edge with valid high and stall low.
// stages and throughput
//   six register stages, s1 to s5 and the output register, which each item
//   passes in order. one item per cycle is taken without a gap while the
//   receiver does not stall; the rate is set by the output register draining.
// reset
//   synchronous, active high; clears every stage valid bit, so the pipeline
//   comes out of reset empty with rsp_valid low.
// stalls
//   rsp_stall holds the output register; each stage still loads while the
//   one after it is empty, so bubbles close up and req_stall rises only when
//   every stage holds an item.
`default_nettype none

module hsv_to_rgb12_led_packer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrlp_pkg::rsp_type rsp_data
);
   import hrlp_pkg::*;

   logic   front_ready, front_valid;
   s3_type front_data;
   logic   scale_ready, scale_valid;
   s5_type scale_data;
   logic   out_ready;

   assign req_stall = !front_ready;

   hrlp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (front_ready),
      .out_valid (front_valid),
      .out_data  (front_data),
      .out_ready (scale_ready)
   );

   hrlp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .in_ready  (scale_ready),
      .out_valid (scale_valid),
      .out_data  (scale_data),
      .out_ready (out_ready)
   );

   hrlp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_data   (scale_data),
      .in_ready  (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ===== sv/hrlp_checker.sv =====
// hrlp_checker: port-level assertions for the hsv to rgb12 led packer
// bound to hsv_to_rgb12_led_packer_unit; uses hrlp_pkg
`default_nettype none

module hrlp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hrlp_pkg::rsp_type rsp_data
);
   import hrlp_pkg::*;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // a free receiver means every stage can move, so the input is never held
   a_no_stall_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while the receiver takes items");

   // frame must agree with the separate fields
   a_frame_packing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.packed_frame == {rsp_data.led_out, rsp_data.red_level,
                                              rsp_data.green_level, rsp_data.blue_level,
                                              {PAD_W{1'b0}}})
      else $error("packed frame does not match the levels");

   // the full channel, gray and black all leave a zero low nibble somewhere
   a_full_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red_level[PAD_W-1:0] == '0) ||
                    (rsp_data.green_level[PAD_W-1:0] == '0) ||
                    (rsp_data.blue_level[PAD_W-1:0] == '0))
      else $error("no channel carries the full brightness");

   // a held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind hsv_to_rgb12_led_packer_unit hrlp_checker u_checker (.*);

`default_nettype wire

// ===== bench/hsv_to_rgb12_led_packer_checker.sv =====
// hsv_to_rgb12_led_packer_checker: watches both channels of the led packer,
// works out each frame from the accepted colour item and compares it on arrival
// depends on hrlp_pkg for the item structs, sector codes and conversion constants
`default_nettype none

module hsv_to_rgb12_led_packer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hrlp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hrlp_pkg::rsp_type rsp_data,
   output int unsigned       fault_count,
   output int unsigned       frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import hrlp_pkg::*;

   rsp_type     frames_due[$];
   int unsigned faults = 0;

   function automatic rsp_type hsv_to_frame(input req_type px);
      rsp_type     f;
      sector_type  sec;
      logic [31:0] h, s, v, full, sec_idx, off, p, q, t, r, g, b;
      h    = 32'(px.hue);
      s    = 32'(px.saturation);
      v    = 32'(px.brightness);
      full = v << 4;
      if (s == 0) begin
         r = full;
         g = full;
         b = full;
      end else if (v == 0) begin
         r = '0;
         g = '0;
         b = '0;
      end else begin
         sec_idx = h / SECTOR_WIDTH;
         sec     = sector_type'(sec_idx[2:0]);
         off     = h - sec_idx * SECTOR_WIDTH;
         if (off > OFF_MAX) off = OFF_MAX;
         p = v * (CHAN_MAX - s);
         q = v * (FULL_SPAN - s * off);
         t = v * (FULL_SPAN - s * (OFF_MAX - off));
         // truncating scale to 12 bits, then clamp
         p = (p * SCALE_NUM) / P_DEN;
         q = (q * SCALE_NUM) / QT_DEN;
         t = (t * SCALE_NUM) / QT_DEN;
         if (p > LEVEL_MAX) p = LEVEL_MAX;
         if (q > LEVEL_MAX) q = LEVEL_MAX;
         if (t > LEVEL_MAX) t = LEVEL_MAX;
         case (sec)
            SEC_RY: begin
               r = full; g = t;    b = p;
            end
            SEC_YG: begin
               r = q;    g = full; b = p;
            end
            SEC_GC: begin
               r = p;    g = full; b = t;
            end
            SEC_CB: begin
               r = p;    g = q;    b = full;
            end
            SEC_BM: begin
               r = t;    g = p;    b = full;
            end
            default: begin
               r = full; g = p;    b = q;
            end
         endcase
      end
      f.led_out      = px.led_index;
      f.red_level    = r[LVL_W-1:0];
      f.green_level  = g[LVL_W-1:0];
      f.blue_level   = b[LVL_W-1:0];
      f.packed_frame = {px.led_index, r[LVL_W-1:0], g[LVL_W-1:0], b[LVL_W-1:0],
                        {PAD_W{1'b0}}};
      return f;
   endfunction

   task automatic check_field(input string label, input logic [FRAME_W-1:0] want,
                              input logic [FRAME_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected item, expected none actual %h", $time, rsp_data);
               faults++;
            end else begin
               due = frames_due.pop_front();
               check_field("led_out", FRAME_W'(due.led_out), FRAME_W'(rsp_data.led_out));
               check_field("red_level", FRAME_W'(due.red_level),
                           FRAME_W'(rsp_data.red_level));
               check_field("green_level", FRAME_W'(due.green_level),
                           FRAME_W'(rsp_data.green_level));
               check_field("blue_level", FRAME_W'(due.blue_level),
                           FRAME_W'(rsp_data.blue_level));
               check_field("packed_frame", due.packed_frame, rsp_data.packed_frame);
            end
         end
         if (req_valid && !req_stall) frames_due.push_back(hsv_to_frame(req_data));
      end
      // registered so the stimulus side reads a stable count after each edge
      fault_count    <= faults;
      frames_pending <= frames_due.size();
   end

endmodule

`default_nettype wire

// ===== bench/hsv_to_rgb12_led_packer_unit_tb.sv =====
// hsv_to_rgb12_led_packer_unit_tb: stimulus and verdict for the led packer
// drives colour items with bursty pacing and receiver stalls; checking is done
// by hsv_to_rgb12_led_packer_checker; depends on hrlp_pkg and the unit
`default_nettype none

module hsv_to_rgb12_led_packer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hrlp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   int unsigned fault_count;
   int unsigned frames_pending;
   logic        hold_go;
   logic        no_gaps;
   int unsigned burst_left;

   hsv_to_rgb12_led_packer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hsv_to_rgb12_led_packer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fault_count    (fault_count),
      .frames_pending (frames_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // offer one item, pacing the sender in bursts, and wait until it is taken
   task automatic offer_pixel(input logic [7:0] led, input logic [7:0] hue,
                              input logic [7:0] sat, input logic [7:0] bright);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0 && !no_gaps) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data  <= '{led_index: led, hue: hue, saturation: sat, brightness: bright};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: stall modes of its own, plus one long hold when asked
   initial begin : rsp_side
      int unsigned mode, mode_left, hold_left, cyc;
      logic        hold_over;
      mode_left = 0;
      hold_left = 0;
      hold_over = 1'b0;
      cyc       = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_go && !hold_over) begin
            hold_over = 1'b1;
            hold_left = 60;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [7:0] sat, bright;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      hold_go    <= 1'b0;
      no_gaps    = 1'b0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // gray: zero saturation, brightness at both ends
      offer_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      offer_pixel(8'd255, 8'd255, 8'd0, 8'd255);
      offer_pixel(8'd17, 8'd128, 8'd0, 8'd128);
      // black: nonzero saturation but no brightness
      offer_pixel(8'd1, 8'd100, 8'd255, 8'd0);
      offer_pixel(8'd2, 8'd0, 8'd1, 8'd0);
      // sector edges at full colour, last sector running to hue 255
      offer_pixel(8'd10, 8'd0, 8'd255, 8'd255);
      offer_pixel(8'd11, 8'd42, 8'd255, 8'd255);
      offer_pixel(8'd12, 8'd43, 8'd255, 8'd255);
      offer_pixel(8'd13, 8'd85, 8'd255, 8'd255);
      offer_pixel(8'd14, 8'd86, 8'd255, 8'd255);
      offer_pixel(8'd15, 8'd128, 8'd255, 8'd255);
      offer_pixel(8'd16, 8'd129, 8'd255, 8'd255);
      offer_pixel(8'd18, 8'd171, 8'd255, 8'd255);
      offer_pixel(8'd19, 8'd172, 8'd255, 8'd255);
      offer_pixel(8'd20, 8'd214, 8'd255, 8'd255);
      offer_pixel(8'd21, 8'd215, 8'd255, 8'd255);
      offer_pixel(8'd22, 8'd255, 8'd255, 8'd255);
      // faint and weakly saturated colours
      offer_pixel(8'd3, 8'd200, 8'd1, 8'd1);
      offer_pixel(8'd254, 8'd30, 8'd255, 8'd1);
      offer_pixel(8'd128, 8'd250, 8'd128, 8'd255);
      offer_pixel(8'd85, 8'd255, 8'd1, 8'd255);

      // sender waits for the pipeline to drain completely
      // the wait starts on a clock edge so the pending count includes the last item
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);

      // long receiver hold against back-to-back items fills every stage
      hold_go <= 1'b1;
      no_gaps = 1'b1;
      repeat (24) offer_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      no_gaps = 1'b0;

      repeat (600) begin
         sat    = 8'($urandom_range(0, 255));
         bright = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0:       sat = 8'd0;
            1:       bright = 8'd0;
            2:       sat = 8'd255;
            3:       bright = 8'd255;
            default: ;
         endcase
         offer_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sat, bright);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== hsv_to_rgb12_led_packer_unit.f =====
sv/hrlp_pkg.sv
sv/hrlp_front.sv
sv/hrlp_scale.sv
sv/hrlp_out.sv
sv/hsv_to_rgb12_led_packer_unit.sv
sv/hrlp_checker.sv
bench/hsv_to_rgb12_led_packer_checker.sv
bench/hsv_to_rgb12_led_packer_unit_tb.sv
